// File: hw/rtl/assert_macros.svh
// assertion macros for the substring search block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

// File: hw/rtl/cisss_pkg.sv
// shared types, constants and functions for the substring search block
package cisss_pkg;

  localparam int MAX_NEEDLE    = 32;
  localparam int POSITION_BITS = 32;
  localparam int LEN_W         = 6;
  localparam int WORD_W        = 64;
  localparam int NEEDLE_WORDS  = 4;
  localparam int NEEDLE_BYTES  = NEEDLE_WORDS * 8;
  localparam int NB_IDX_W      = $clog2(NEEDLE_BYTES);
  localparam int INDEX_W       = 32;
  localparam int ADDR_W        = 6;
  localparam int REG_SEL_W     = 3;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [7:0] FOLD_MASK = 8'hDF;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_Z    = 8'h5A;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_LENGTH = 3'd0,
    REG_WORD0  = 3'd1,
    REG_WORD1  = 3'd2,
    REG_WORD2  = 3'd3,
    REG_WORD3  = 3'd4
  } reg_sel_t;

  typedef logic [NEEDLE_WORDS-1:0][WORD_W-1:0] words_t;
  typedef logic [MAX_NEEDLE-1:0][7:0]          window_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    window_t               aligned;
    logic [MAX_NEEDLE-1:0] mask;
    logic                  len_ok;
    logic                  len_zero;
    logic [LEN_W-1:0]      len;
  } needle_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } result_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] u;
    u = c & FOLD_MASK;
    return (u >= CHAR_A && u <= CHAR_Z) ? u : c;
  endfunction

  function automatic logic [7:0] needle_byte(input words_t words, input logic [LEN_W-1:0] k);
    logic [NEEDLE_BYTES-1:0][7:0] bytes;
    bytes = words;
    if (32'(k) >= NEEDLE_BYTES) begin
      return 8'd0;
    end
    return bytes[k[NB_IDX_W-1:0]];
  endfunction

endpackage

// File: hw/rtl/cisss_needle_align.sv
// lines the needle up against the window, newest byte first, and registers it
module cisss_needle_align
  import cisss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] needle_length,
  input  words_t           needle_words,
  output needle_t          needle
);

  needle_t needle_next;

  always_comb begin
    needle_next = '0;
    needle_next.len      = needle_length;
    needle_next.len_zero = (needle_length == '0);
    needle_next.len_ok   = (needle_length != '0) && (32'(needle_length) <= MAX_NEEDLE);
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      needle_next.mask[j] = (needle_length > LEN_W'(j));
      needle_next.aligned[j] =
        needle_byte(needle_words, LEN_W'(needle_length - LEN_W'(j) - LEN_W'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle <= '0;
    end else begin
      needle <= needle_next;
    end
  end

endmodule

// File: hw/rtl/cisss_match.sv
// folded byte window, full needle compare, position count and first match
module cisss_match
  import cisss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  needle_t needle,
  output result_t result
);

  window_t                  window;
  window_t                  window_next;
  logic [POSITION_BITS-1:0] bytes_seen;
  logic [POSITION_BITS-1:0] bytes_seen_next;
  logic                     match_seen;
  logic                     match_seen_next;
  logic [POSITION_BITS-1:0] match_start;
  logic [POSITION_BITS-1:0] match_start_next;
  logic [MAX_NEEDLE-1:0]    eq;
  logic                     hit;

  always_comb begin
    window_next[0] = fold_upper(item.data_byte);
    for (int j = 1; j < MAX_NEEDLE; j++) begin
      window_next[j] = window[j-1];
    end
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      eq[j] = !needle.mask[j] || (window_next[j] == needle.aligned[j]);
    end
    bytes_seen_next = (bytes_seen == POS_MAX) ? bytes_seen : bytes_seen + POSITION_BITS'(1);
    hit = !match_seen && needle.len_ok && (&eq) &&
          (bytes_seen_next >= POSITION_BITS'(needle.len));
    match_seen_next  = match_seen || hit;
    match_start_next = hit ? bytes_seen_next - POSITION_BITS'(needle.len) : match_start;
  end

  always_comb begin
    if (needle.len_zero) begin
      result.found       = 1'b1;
      result.match_index = '0;
    end else if (match_seen_next) begin
      result.found       = 1'b1;
      result.match_index = match_start_next[INDEX_W-1:0];
    end else begin
      result.found       = 1'b0;
      result.match_index = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (fire) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= '0;
      match_seen  <= 1'b0;
      match_start <= '0;
    end else if (fire) begin
      if (item.last_byte) begin
        bytes_seen  <= '0;
        match_seen  <= 1'b0;
        match_start <= '0;
      end else begin
        bytes_seen  <= bytes_seen_next;
        match_seen  <= match_seen_next;
        match_start <= match_start_next;
      end
    end
  end

endmodule

// File: hw/rtl/case_insensitive_substring_search.sv
// one haystack byte is taken per cycle while in_ready is high; a held last byte stalls input
// a result passes through the input register, then the compare of the folded window against
//   the needle feeds the result register
// the needle registers feed an alignment register, so an item must follow a write by a cycle
// reset clears the search state, the needle registers and both handshake stages
// top level of the case-insensitive substring search block
module case_insensitive_substring_search
  import cisss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [WORD_W-1:0]  pwdata,
  output logic [WORD_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [INDEX_W-1:0] match_index
);

`include "assert_macros.svh"

  logic [LEN_W-1:0] needle_length;
  words_t           needle_words;
  needle_t          needle;
  reg_sel_t         reg_sel;
  logic             wr_en;

  item_t   s1;
  logic    s1_valid;
  logic    s1_fire;
  result_t result;
  result_t out_beat;

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[ADDR_W-1:ADDR_W-REG_SEL_W]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_length <= '0;
      needle_words  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_LENGTH: needle_length   <= pwdata[LEN_W-1:0];
        REG_WORD0:  needle_words[0] <= pwdata;
        REG_WORD1:  needle_words[1] <= pwdata;
        REG_WORD2:  needle_words[2] <= pwdata;
        REG_WORD3:  needle_words[3] <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LENGTH: prdata = WORD_W'(needle_length);
      REG_WORD0:  prdata = needle_words[0];
      REG_WORD1:  prdata = needle_words[1];
      REG_WORD2:  prdata = needle_words[2];
      REG_WORD3:  prdata = needle_words[3];
      default:    prdata = '0;
    endcase
  end

  cisss_needle_align u_align (
    .clk           (clk),
    .rst           (rst),
    .needle_length (needle_length),
    .needle_words  (needle_words),
    .needle        (needle)
  );

  // a last byte waits in the input register until the result slot frees
  assign s1_fire  = s1_valid && (!s1.last_byte || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1.data_byte <= data_byte;
      s1.last_byte <= last_byte;
    end
  end

  cisss_match u_match (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_fire),
    .item   (s1),
    .needle (needle),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.last_byte) begin
      out_beat <= result;
    end
  end

  assign found       = out_beat.found;
  assign match_index = out_beat.match_index;

  `ASSERT_IMPLY(a_index_zero_when_missing, clk, rst, out_valid && !found, match_index == '0)
  `ASSERT_NEXT(a_last_makes_result, clk, rst, s1_fire && s1.last_byte, out_valid)
  `ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !s1_fire, s1_valid)

endmodule
